### hw/rtl/positional_list_store_top_assert.svh
// ----------------------------------------------------------------------------
// positional list store assertion macros
// shared property forms for the list store checks
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_STORE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PLS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// sizes, codes and shared types of the positional list store
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int FCNT_W = 5;
    localparam int ELEM_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_POS   = 3'd5,
        FN_DUMP      = 3'd6
    } func_t;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] bound;
        logic             dec;
    } step_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] nxt;
        logic             hit;
    } step_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram
// single write port, single registered read port slot memory
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/pls_step_unit.sv
// ----------------------------------------------------------------------------
// pls_step_unit
// shared cursor step: next slot index and end-of-walk compare
// ----------------------------------------------------------------------------
`default_nettype none

module pls_step_unit (
    input  wire pls_pkg::step_req_t req,
    output pls_pkg::step_rsp_t      rsp
);

    import pls_pkg::*;

    always_comb begin
        rsp.nxt = req.dec ? (req.cur - IDX_W'(1)) : (req.cur + IDX_W'(1));
        rsp.hit = (req.cur == req.bound);
    end

endmodule

`default_nettype wire

### hw/rtl/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top
// bounded ordered list with positional insert, delete and dump
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one operation per transfer: s_tuser selects it, s_tdata
//   holds the data word and the 1-based position. s_tready is high only while
//   the sequencer is idle; one operation is worked on at a time.
//   m_ channel returns one result per operation, or one per stored element
//   for a dump, with m_tlast on the final result of the operation.
// data path:
//   the slots live in a memory with one write port and one registered read
//   port; every shifted slot is read and then written one place over through
//   the shared cursor step unit. a rejected operation or an empty dump goes
//   straight to its result. a dump reads each stored element and then
//   presents it, one element at a time, before reading the next.
// reset:
//   aresetn clears the element count, the sequencer and the output valid;
//   no memory clearing pass is run, the block is ready once the sequencer is idle.
// stall:
//   a held result keeps m_tdata stable and the sequencer waits at its next
//   result; a new operation may be accepted while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pls_pkg::S_DATA_W-1:0]  s_tdata,   // value[31:0], position[36:32]
    input  wire logic [pls_pkg::FUNC_W-1:0]    s_tuser,   // func[2:0]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pls_pkg::M_DATA_W-1:0]  m_tdata,   // status[1:0], count[6:2], element[38:7]
    output logic                               m_tuser,   // element_valid[0]
    output logic                               m_tlast
);

    import pls_pkg::*;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_INS_CHK,
        SQ_INS_WR,
        SQ_DEL_CHK,
        SQ_DEL_WR,
        SQ_DUMP_RD,
        SQ_DUMP_OUT,
        SQ_RESP
    } seq_state_t;

    seq_state_t             state_reg,  state_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic [IDX_W-1:0]       bound_reg,  bound_next;
    logic [DATA_WIDTH-1:0]  value_reg,  value_next;
    logic [STAT_W-1:0]      status_reg, status_next;

    logic                   m_tvalid_reg,   m_tvalid_next;
    logic [STAT_W-1:0]      out_status_reg, out_status_next;
    logic [FCNT_W-1:0]      out_count_reg,  out_count_next;
    logic [ELEM_W-1:0]      out_elem_reg,   out_elem_next;
    logic                   out_evalid_reg, out_evalid_next;
    logic                   out_last_reg,   out_last_next;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [DATA_WIDTH-1:0]  mem_wdata;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic [DATA_WIDTH-1:0]  mem_rdata;

    step_req_t              step_req;
    step_rsp_t              step_rsp;

    func_t                  fn;
    logic [POS_W-1:0]       s_pos;
    logic [CMP_W-1:0]       pos_x;
    logic [CMP_W-1:0]       cnt_x;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       pos_idx;
    logic                   list_full;
    logic                   list_empty;
    logic                   ins_pos_ok;
    logic                   del_pos_ok;
    logic                   out_free;
    logic [63:0]            elem_wide;

    pls_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    pls_step_unit u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    assign fn         = func_t'(s_tuser);
    assign s_pos      = s_tdata[ELEM_W +: POS_W];
    assign pos_x      = CMP_W'(s_pos);
    assign cnt_x      = CMP_W'(count_reg);
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign pos_idx    = IDX_W'(pos_x - CMP_W'(1));
    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);
    assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
    assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign elem_wide  = 64'(mem_rdata);

    assign s_tready = (state_reg == SQ_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        bound_next      = bound_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_elem_next   = out_elem_reg;
        out_evalid_next = out_evalid_reg;
        out_last_next   = out_last_reg;

        step_req.cur   = cursor_reg;
        step_req.bound = bound_reg;
        step_req.dec   = (state_reg == SQ_INS_CHK) || (state_reg == SQ_INS_WR);

        mem_we    = 1'b0;
        mem_waddr = cursor_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = step_rsp.nxt;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            SQ_IDLE: begin
                if (s_tvalid) begin
                    value_next  = DATA_WIDTH'(s_tdata[ELEM_W-1:0]);
                    status_next = STAT_OK;
                    state_next  = SQ_RESP;
                    unique case (fn) inside
                        FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
                            cursor_next = IDX_W'(count_reg);
                            if (list_full) begin
                                status_next = STAT_FULL;
                            end else if ((fn == FN_INS_POS) && !ins_pos_ok) begin
                                status_next = STAT_INVALID;
                            end else begin
                                state_next = SQ_INS_CHK;
                                if (fn == FN_INS_FRONT) begin
                                    bound_next = '0;
                                end else if (fn == FN_INS_BACK) begin
                                    bound_next = IDX_W'(count_reg);
                                end else begin
                                    bound_next = pos_idx;
                                end
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
                            bound_next = last_idx;
                            if (list_empty) begin
                                status_next = STAT_EMPTY;
                            end else if ((fn == FN_DEL_POS) && !del_pos_ok) begin
                                status_next = STAT_INVALID;
                            end else begin
                                state_next = SQ_DEL_CHK;
                                if (fn == FN_DEL_FRONT) begin
                                    cursor_next = '0;
                                end else if (fn == FN_DEL_BACK) begin
                                    cursor_next = last_idx;
                                end else begin
                                    cursor_next = pos_idx;
                                end
                            end
                        end
                        FN_DUMP: begin
                            cursor_next = '0;
                            bound_next  = last_idx;
                            if (!list_empty) begin
                                state_next = SQ_DUMP_RD;
                            end
                        end
                        default: begin
                            status_next = STAT_INVALID;
                        end
                    endcase
                end
            end
            SQ_INS_CHK: begin
                if (step_rsp.hit) begin
                    mem_we     = 1'b1;
                    mem_wdata  = value_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = SQ_RESP;
                end else begin
                    mem_re     = 1'b1;
                    state_next = SQ_INS_WR;
                end
            end
            SQ_INS_WR: begin
                mem_we      = 1'b1;
                cursor_next = step_rsp.nxt;
                state_next  = SQ_INS_CHK;
            end
            SQ_DEL_CHK: begin
                if (step_rsp.hit) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = SQ_RESP;
                end else begin
                    mem_re     = 1'b1;
                    state_next = SQ_DEL_WR;
                end
            end
            SQ_DEL_WR: begin
                mem_we      = 1'b1;
                cursor_next = step_rsp.nxt;
                state_next  = SQ_DEL_CHK;
            end
            SQ_DUMP_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = cursor_reg;
                state_next = SQ_DUMP_OUT;
            end
            SQ_DUMP_OUT: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = STAT_OK;
                    out_count_next  = FCNT_W'(count_reg);
                    out_elem_next   = elem_wide[ELEM_W-1:0];
                    out_evalid_next = 1'b1;
                    out_last_next   = step_rsp.hit;
                    if (step_rsp.hit) begin
                        state_next = SQ_IDLE;
                    end else begin
                        cursor_next = step_rsp.nxt;
                        state_next  = SQ_DUMP_RD;
                    end
                end
            end
            SQ_RESP: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = FCNT_W'(count_reg);
                    out_elem_next   = '0;
                    out_evalid_next = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SQ_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cursor_reg     <= cursor_next;
        bound_reg      <= bound_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_elem_reg   <= out_elem_next;
        out_evalid_reg <= out_evalid_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_elem_reg, out_count_reg, out_status_reg};
    assign m_tuser  = out_evalid_reg;
    assign m_tlast  = out_last_reg;

    `include "positional_list_store_top_assert.svh"

    // element count stays within the list capacity
    `PLS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count above depth")

    // count moves by at most one element per cycle
    `PLS_ASSERT_NXT(a_count_step, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1))
            || (count_reg == $past(count_reg) - CNT_W'(1)), "count jumped")

    // a result carrying an element always reports ok
    `PLS_ASSERT_IMP(a_elem_ok, m_tvalid_reg && out_evalid_reg, out_status_reg == STAT_OK, "element with error status")

    // the count only changes when the walk finishes and a result is due
    `PLS_ASSERT_NXT(a_count_resp, state_reg != SQ_INS_CHK && state_reg != SQ_DEL_CHK,
        count_reg == $past(count_reg), "count changed outside walk end")

endmodule

`default_nettype wire
